@@ hdl/markup_tag_text_tokenizer_core_macros.svh @@
// assertion helpers for the tokenizer core
`ifndef MARKUP_TAG_TEXT_TOKENIZER_CORE_MACROS_SVH
`define MARKUP_TAG_TEXT_TOKENIZER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define MTTT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define MTTT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`define MTTT_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`else

`define MTTT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)

`define MTTT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`define MTTT_ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

@@ hdl/mttt_pkg.sv @@
package mttt_pkg;

   localparam logic [6:0] NAME_MAX = 7'd127;
   localparam logic [6:0] TEXT_MAX = 7'd127;

   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [1:0] KIND_OPEN  = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_TEXT  = 2'd2;

   typedef enum logic [2:0] {
      MODE_TEXT_TRIM  = 3'd0,
      MODE_TEXT       = 3'd1,
      MODE_OPEN_TRIM  = 3'd2,
      MODE_SLASH_TRIM = 3'd3,
      MODE_NAME       = 3'd4,
      MODE_SKIP       = 3'd5
   } mode_type;

   typedef struct packed {
      logic       valid;
      logic       cmd;
      logic [7:0] byte_in;
   } item_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic       has_char;
      logic [7:0] char_out;
      logic       last;
   } result_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_name_rest(input logic [7:0] c);
      return is_alpha(c) || ((c >= 8'h30) && (c <= 8'h39)) || (c == CHAR_DASH);
   endfunction

endpackage

@@ hdl/markup_tag_text_tokenizer_core.sv @@
// Markup tokenizer: one byte (or an end-of-buffer marker) per transfer in, at most one token
// character per transfer out, tagged open tag, close tag or text, with tlast on the final
// transfer of each token. A new byte is taken every cycle while the result is not stalled; a
// byte passes from the input register through the combinational scanner step into the result
// register, and a stalled result holds back input only once both registers are full. Output
// trails input by one character, since the newest character is held until the next byte or
// the token end shows whether it is the last; send an end-of-buffer marker to flush the final
// token.
module markup_tag_text_tokenizer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] byte_in
   input  logic       req_tuser,   // [0] cmd
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] char_out
   output logic [2:0] rsp_tuser,   // [1:0] kind, [2] has_char
   output logic       rsp_tlast
);
   import mttt_pkg::*;

   item_type   item;
   result_type res;
   logic       stage_ready;
   logic       advance;
   logic [1:0] kind;
   logic       has_char;

   assign advance = item.valid && stage_ready;

   mttt_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (req_tuser),
      .byte_in    (req_tdata),
      .advance    (advance),
      .item       (item)
   );

   mttt_fsm u_fsm (
      .clock (clock),
      .reset (reset),
      .item  (item),
      .fire  (advance),
      .res   (res)
   );

   mttt_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (advance && res.valid),
      .res         (res),
      .stage_ready (stage_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .kind        (kind),
      .has_char    (has_char),
      .char_out    (rsp_tdata),
      .token_last  (rsp_tlast)
   );

   assign rsp_tuser = {has_char, kind};

endmodule

@@ hdl/mttt_in_reg.sv @@
module mttt_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               cmd,
   input  logic [7:0]         byte_in,
   input  logic               advance,
   output mttt_pkg::item_type item
);
   import mttt_pkg::*;

   logic       valid_ff, valid_in;
   logic       cmd_ff;
   logic [7:0] byte_ff;

   // slot frees up when the held item moves on this cycle
   assign req_tready = !valid_ff || advance;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_ff  <= cmd;
         byte_ff <= byte_in;
      end
   end

   assign item.valid   = valid_ff;
   assign item.cmd     = cmd_ff;
   assign item.byte_in = byte_ff;

endmodule

@@ hdl/mttt_fsm.sv @@
`include "markup_tag_text_tokenizer_core_macros.svh"

module mttt_fsm (
   input  logic                 clock,
   input  logic                 reset,
   input  mttt_pkg::item_type   item,
   input  logic                 fire,
   output mttt_pkg::result_type res
);
   import mttt_pkg::*;

   mode_type   mode_ff, mode_in;
   logic       close_ff, close_in;
   logic [7:0] held_char_ff, held_char_in;
   logic       held_valid_ff, held_valid_in;
   logic [6:0] len_ff, len_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_TEXT_TRIM;
         close_ff      <= 1'b0;
         held_char_ff  <= 8'd0;
         held_valid_ff <= 1'b0;
         len_ff        <= 7'd0;
      end else if (fire) begin
         mode_ff       <= mode_in;
         close_ff      <= close_in;
         held_char_ff  <= held_char_in;
         held_valid_ff <= held_valid_in;
         len_ff        <= len_in;
      end
   end

   always_comb begin
      logic       take_en;
      logic [1:0] take_kind;
      logic [7:0] take_char;
      logic [6:0] take_limit;
      logic       fin_en;
      logic [1:0] fin_kind;
      logic       clr_en;
      logic       start_name;
      logic [1:0] name_kind;
      logic [7:0] c;
      logic [7:0] base_hc;
      logic       base_hv;
      logic [6:0] base_len;

      c          = item.byte_in;
      mode_in    = mode_ff;
      close_in   = close_ff;
      take_en    = 1'b0;
      take_kind  = KIND_TEXT;
      take_char  = c;
      take_limit = TEXT_MAX;
      fin_en     = 1'b0;
      fin_kind   = close_ff ? KIND_CLOSE : KIND_OPEN;
      clr_en     = 1'b0;
      start_name = 1'b0;

      if (item.cmd) begin
         // end of buffer flushes whatever token is pending
         if (mode_ff == MODE_TEXT) begin
            fin_en   = held_valid_ff;
            fin_kind = KIND_TEXT;
         end else if (mode_ff == MODE_NAME || mode_ff == MODE_OPEN_TRIM ||
                      mode_ff == MODE_SLASH_TRIM) begin
            fin_en = 1'b1;
         end
      end else begin
         unique case (mode_ff)
            MODE_TEXT: begin
               if (c == CHAR_LT) begin
                  fin_en   = held_valid_ff;
                  fin_kind = KIND_TEXT;
                  mode_in  = MODE_OPEN_TRIM;
               end else begin
                  take_en   = 1'b1;
                  take_char = (c == CHAR_LF) ? CHAR_SPACE : c;
               end
            end
            MODE_OPEN_TRIM: begin
               if (!is_space(c)) begin
                  if (c == CHAR_SLASH) begin
                     close_in = 1'b1;
                     mode_in  = MODE_SLASH_TRIM;
                  end else begin
                     close_in   = 1'b0;
                     start_name = 1'b1;
                  end
               end
            end
            MODE_SLASH_TRIM: begin
               if (!is_space(c)) begin
                  start_name = 1'b1;
               end
            end
            MODE_NAME: begin
               if (is_name_rest(c)) begin
                  take_en    = 1'b1;
                  take_kind  = close_ff ? KIND_CLOSE : KIND_OPEN;
                  take_limit = NAME_MAX;
               end else begin
                  fin_en  = 1'b1;
                  mode_in = (c == CHAR_GT) ? MODE_TEXT_TRIM : MODE_SKIP;
               end
            end
            MODE_SKIP: begin
               if (c == CHAR_GT) begin
                  mode_in = MODE_TEXT_TRIM;
               end
            end
            default: begin
               // leading trim of a text run
               if (!is_space(c)) begin
                  clr_en = 1'b1;
                  if (c == CHAR_LT) begin
                     mode_in = MODE_OPEN_TRIM;
                  end else begin
                     mode_in = MODE_TEXT;
                     take_en = 1'b1;
                  end
               end
            end
         endcase
      end

      // first character after the tag opener decides on a name
      name_kind = close_in ? KIND_CLOSE : KIND_OPEN;
      if (start_name) begin
         clr_en = 1'b1;
         if (is_alpha(c)) begin
            mode_in    = MODE_NAME;
            take_en    = 1'b1;
            take_kind  = name_kind;
            take_limit = NAME_MAX;
         end else begin
            mode_in  = (c == CHAR_GT) ? MODE_TEXT_TRIM : MODE_SKIP;
            fin_en   = 1'b1;
            fin_kind = name_kind;
         end
      end

      base_hc  = clr_en ? 8'd0 : held_char_ff;
      base_hv  = clr_en ? 1'b0 : held_valid_ff;
      base_len = clr_en ? 7'd0 : len_ff;

      held_char_in  = base_hc;
      held_valid_in = base_hv;
      len_in        = base_len;

      res.valid    = 1'b0;
      res.kind     = take_kind;
      res.has_char = 1'b1;
      res.char_out = base_hc;
      res.last     = 1'b0;

      if (take_en) begin
         // past the limit the character is dropped
         if (base_len < take_limit) begin
            res.valid     = base_hv;
            held_char_in  = take_char;
            held_valid_in = 1'b1;
            len_in        = base_len + 7'd1;
         end
      end else if (fin_en) begin
         res.valid     = 1'b1;
         res.kind      = fin_kind;
         res.has_char  = base_hv;
         res.char_out  = base_hv ? base_hc : 8'd0;
         res.last      = 1'b1;
         held_char_in  = 8'd0;
         held_valid_in = 1'b0;
         len_in        = 7'd0;
      end

      if (item.cmd) begin
         mode_in       = MODE_TEXT_TRIM;
         close_in      = 1'b0;
         held_char_in  = 8'd0;
         held_valid_in = 1'b0;
         len_in        = 7'd0;
      end
   end

   `MTTT_ASSERT_IMP(a_nameless_ends_tag, clock, reset, fire && res.valid && !res.has_char, res.last && (res.kind != KIND_TEXT), "result without character must end a tag token")
   `MTTT_ASSERT_NEVER(a_idle_modes_hold_nothing, clock, reset, (mode_ff == MODE_TEXT_TRIM || mode_ff == MODE_SKIP) && held_valid_ff, "held character outside a token")
   `MTTT_ASSERT_IMP(a_held_counts, clock, reset, held_valid_ff, len_ff != 7'd0, "held character with zero token length")
   `MTTT_ASSERT_NEXT(a_flush_resets, clock, reset, fire && item.cmd, (mode_ff == MODE_TEXT_TRIM) && !held_valid_ff && (len_ff == 7'd0) && !close_ff, "end of buffer did not return to reset state")

endmodule

@@ hdl/mttt_out_reg.sv @@
module mttt_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  mttt_pkg::result_type res,
   output logic                 stage_ready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [1:0]           kind,
   output logic                 has_char,
   output logic [7:0]           char_out,
   output logic                 token_last
);
   import mttt_pkg::*;

   logic       valid_ff, valid_in;
   logic [1:0] kind_ff;
   logic       has_ff;
   logic [7:0] char_ff;
   logic       last_ff;

   // can take a new result when empty or when the current one transfers now
   assign stage_ready = !valid_ff || rsp_tready;
   assign valid_in    = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= res.kind;
         has_ff  <= res.has_char;
         char_ff <= res.char_out;
         last_ff <= res.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign kind       = kind_ff;
   assign has_char   = has_ff;
   assign char_out   = char_ff;
   assign token_last = last_ff;

endmodule
